/* hdl/bcf_pkg.sv */
// Shared types and constants for the chunk boundary finder.
// Request and result payload structs, request codes, register indexes.
// No dependencies.
package bcf_pkg;

    localparam int OFFSET_W   = 27;
    localparam int WLEN_W     = 12;
    localparam int HASH_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int TIDX_W     = 8;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    typedef logic [REQ_W-1:0]     t_req_type;
    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    // Request codes; code 3 is unused and does nothing.
    localparam t_req_type REQ_LOAD    = 2'd0;
    localparam t_req_type REQ_DATA    = 2'd1;
    localparam t_req_type REQ_RESTART = 2'd2;

    // Configuration register indexes.
    localparam t_cfg_index CFG_MIN_SIZE = 8'd0;
    localparam t_cfg_index CFG_MAX_SIZE = 8'd1;
    localparam t_cfg_index CFG_WINDOW   = 8'd2;
    localparam t_cfg_index CFG_MASK     = 8'd3;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [TIDX_W-1:0] table_index;
        logic [HASH_W-1:0] table_word;
        logic [BYTE_W-1:0] data_byte;
    } t_req;

    typedef struct packed {
        logic [OFFSET_W-1:0] cut_offset;
        logic                hash_matched;
    } t_res;

    // Rotate a hash word left by 0..31.
    function automatic logic [HASH_W-1:0] rotl(input logic [HASH_W-1:0] v,
                                               input logic [4:0] s);
        logic [2*HASH_W-1:0] d;
        d = {v, v} << s;
        return d[2*HASH_W-1:HASH_W];
    endfunction

endpackage

/* hdl/bcf_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Read-first when read and write hit the same address. No dependencies.
module bcf_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/buzhash_chunk_boundary_finder_unit.sv */
// Top level of the rolling-hash chunk boundary finder.
// Uses bcf_pkg (types, codes, rotl) and bcf_ram (hash table copies, byte ring).
//
//   channel   direction  handshake                 payload
//   ------    ---------  ------------------------  ------------------------
//   in        to block   i_in_valid / o_in_stall   i_in_data   (t_req)
//   out       from block o_out_valid / i_out_stall o_out_data  (t_res)
//   cfg       to block   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One request transfer per cycle while input is not held; the hash recurrence
// closes within the last stage, so bytes stream back to back.
// A byte's result enters the result queue after its transfer: ring read in
// the transfer cycle, then table read of the byte leaving the window, then
// hash update and test.
// After reset and after each config write, input holds while the window
// length modulo the ring depth is recomputed.
// Input also holds when queued results plus bytes in flight fill the
// 4-entry result queue; a stalled output never drops or repeats a result.
module buzhash_chunk_boundary_finder_unit #(
    parameter int WINDOW_DEPTH  = 4096,
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  bcf_pkg::t_req                  i_in_data,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output bcf_pkg::t_res                  o_out_data,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bcf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bcf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import bcf_pkg::*;

    localparam int AW   = $clog2(WINDOW_DEPTH);
    localparam int TAW  = $clog2(TABLE_ENTRIES);
    localparam int DW   = $clog2(WINDOW_DEPTH + 1);
    localparam int OW1  = OFFSET_W + 1;

    // Window length mod ring depth: reciprocal multiply, then one correction.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP       = (1 << RECIP_SHIFT) / WINDOW_DEPTH;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int P1W         = WLEN_W + RECIP_W;
    localparam int P2W         = WLEN_W + DW;

    localparam int FIFO_DEPTH = 4;
    localparam int FPW        = $clog2(FIFO_DEPTH);
    localparam int FCW        = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] SETTLE_CYCLES = 2'd3;

    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_DATA    = 2'd1,
        OP_RESTART = 2'd2
    } t_op;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [OFFSET_W-1:0] r_min;
    logic [OFFSET_W-1:0] r_max;
    logic [WLEN_W-1:0]   r_wlen;
    logic [HASH_W-1:0]   r_mask;
    logic [1:0]          r_settle;
    logic                s_cfg_we;

    assign o_cfg_ready = 1'b1;
    assign s_cfg_we    = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= OFFSET_W'(524288);
            r_max    <= OFFSET_W'(8388608);
            r_wlen   <= WLEN_W'(4095);
            r_mask   <= HASH_W'(2097151);
            r_settle <= SETTLE_CYCLES;
        end else begin
            if (s_cfg_we) begin
                r_settle <= SETTLE_CYCLES;
                unique case (i_cfg_index)
                    CFG_MIN_SIZE: r_min  <= i_cfg_data[OFFSET_W-1:0];
                    CFG_MAX_SIZE: r_max  <= i_cfg_data[OFFSET_W-1:0];
                    CFG_WINDOW:   r_wlen <= i_cfg_data[WLEN_W-1:0];
                    CFG_MASK:     r_mask <= i_cfg_data[HASH_W-1:0];
                    default:      ;
                endcase
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    // A zero window length acts as one.
    logic [WLEN_W-1:0] s_weff;
    assign s_weff = (r_wlen == '0) ? WLEN_W'(1) : r_wlen;

    // ---------------------------------------------------------------
    // Window length modulo ring depth, three registered steps
    // ---------------------------------------------------------------
    logic [P1W-1:0]    r_wm_prod1;
    logic [WLEN_W-1:0] r_wm_w1;
    logic [P2W-1:0]    r_wm_prod2;
    logic [WLEN_W-1:0] r_wm_w2;
    logic [AW-1:0]     r_wmod;
    logic [WLEN_W-1:0] s_wm_quot;
    logic [P2W-1:0]    s_wm_diff;

    assign s_wm_quot = WLEN_W'(r_wm_prod1 >> RECIP_SHIFT);
    assign s_wm_diff = P2W'(r_wm_w2) - r_wm_prod2;

    always_ff @(posedge i_clk) begin
        r_wm_prod1 <= P1W'(s_weff) * P1W'(RECIP);
        r_wm_w1    <= s_weff;
        r_wm_prod2 <= P2W'(s_wm_quot) * P2W'(WINDOW_DEPTH);
        r_wm_w2    <= r_wm_w1;
        if (s_wm_diff >= P2W'(WINDOW_DEPTH)) begin
            r_wmod <= AW'(s_wm_diff - P2W'(WINDOW_DEPTH));
        end else begin
            r_wmod <= AW'(s_wm_diff);
        end
    end

    // ---------------------------------------------------------------
    // Front: request transfer, offset counter, memory accesses
    // ---------------------------------------------------------------
    logic                r_s1_roll, r_s1_build, r_s1_comp;
    logic [OFFSET_W-1:0] r_s1_pos;
    t_op                 r_s1_op;
    t_op                 r_s2_op;
    logic [FCW-1:0]      r_count;
    logic [FCW-1:0]      s_inflight;

    logic                s_acc;
    logic                s_sat;
    logic                s_take;
    logic                s_is_load;
    logic [OW1-1:0]      s_mw;
    logic [OW1-1:0]      s_off1;
    logic                s_roll, s_build, s_comp;
    logic [OFFSET_W-1:0] s_pos;
    logic [OFFSET_W-1:0] r_off;
    logic [AW-1:0]       r_wptr;
    logic [AW-1:0]       s_rptr;
    logic [AW-1:0]       s_wptr_inc;

    assign s_inflight = FCW'(r_s1_op == OP_DATA) + FCW'(r_s2_op == OP_DATA);
    // Hold input while settling, or when a new byte could find no queue slot.
    assign o_in_stall = (r_settle != 2'd0) ||
                        ((r_count + s_inflight) >= FCW'(FIFO_DEPTH));
    assign s_acc      = i_in_valid & ~o_in_stall;

    assign s_sat      = &r_off;
    assign s_take     = (i_in_data.req_type == REQ_DATA) && !s_sat;
    assign s_is_load  = (i_in_data.req_type == REQ_LOAD);

    assign s_mw    = {1'b0, r_min} + OW1'(s_weff);
    assign s_off1  = {1'b0, r_off} + OW1'(1);
    assign s_roll  = {1'b0, r_off} >= s_mw;
    assign s_build = r_off >= r_min;
    assign s_comp  = s_off1 >= s_mw;
    assign s_pos   = OFFSET_W'(s_off1 - OW1'(s_weff));

    // Ring slot of the byte leaving the window: offset minus length, wrapped.
    always_comb begin
        if (r_wptr >= r_wmod) begin
            s_rptr = r_wptr - r_wmod;
        end else begin
            s_rptr = AW'({1'b0, r_wptr} + (AW+1)'(WINDOW_DEPTH) - {1'b0, r_wmod});
        end
    end

    assign s_wptr_inc = (r_wptr == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wptr + AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off  <= '0;
            r_wptr <= '0;
        end else if (s_acc) begin
            if (i_in_data.req_type == REQ_RESTART) begin
                r_off  <= '0;
                r_wptr <= '0;
            end else if (s_take) begin
                r_off  <= s_off1[OFFSET_W-1:0];
                r_wptr <= s_wptr_inc;
            end
        end
    end

    logic [BYTE_W-1:0] w_old_byte;
    logic [HASH_W-1:0] w_tab_new;
    logic [HASH_W-1:0] w_tab_old;

    bcf_ram #(.WIDTH(BYTE_W), .DEPTH(WINDOW_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (s_acc && s_take),
        .i_waddr (r_wptr),
        .i_wdata (i_in_data.data_byte),
        .i_raddr (s_rptr),
        .o_rdata (w_old_byte)
    );

    // Two table copies, written together: one for the incoming byte,
    // one for the byte leaving the window.
    bcf_ram #(.WIDTH(HASH_W), .DEPTH(TABLE_ENTRIES)) u_table_new (
        .i_clk   (i_clk),
        .i_we    (s_acc && s_is_load),
        .i_waddr (i_in_data.table_index[TAW-1:0]),
        .i_wdata (i_in_data.table_word),
        .i_raddr (i_in_data.data_byte[TAW-1:0]),
        .o_rdata (w_tab_new)
    );

    bcf_ram #(.WIDTH(HASH_W), .DEPTH(TABLE_ENTRIES)) u_table_old (
        .i_clk   (i_clk),
        .i_we    (s_acc && s_is_load),
        .i_waddr (i_in_data.table_index[TAW-1:0]),
        .i_wdata (i_in_data.table_word),
        .i_raddr (w_old_byte[TAW-1:0]),
        .o_rdata (w_tab_old)
    );

    // ---------------------------------------------------------------
    // Pipeline stages 1 and 2
    // ---------------------------------------------------------------
    logic                r_s2_roll, r_s2_build, r_s2_comp, r_s2_at_max;
    logic [OFFSET_W-1:0] r_s2_pos;
    logic [HASH_W-1:0]   r_s2_add;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_op <= OP_NONE;
            r_s2_op <= OP_NONE;
        end else begin
            if (!s_acc) begin
                r_s1_op <= OP_NONE;
            end else if (i_in_data.req_type == REQ_RESTART) begin
                r_s1_op <= OP_RESTART;
            end else if (s_take) begin
                r_s1_op <= OP_DATA;
            end else begin
                r_s1_op <= OP_NONE;
            end
            r_s2_op <= r_s1_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_roll   <= s_roll;
        r_s1_build  <= s_build;
        r_s1_comp   <= s_comp;
        r_s1_pos    <= s_pos;
        r_s2_roll   <= r_s1_roll;
        r_s2_build  <= r_s1_build;
        r_s2_comp   <= r_s1_comp;
        r_s2_pos    <= r_s1_pos;
        r_s2_at_max <= (r_s1_pos == r_max);
        r_s2_add    <= w_tab_new;
    end

    // ---------------------------------------------------------------
    // Stage 2: hash update, cut test
    // ---------------------------------------------------------------
    logic [HASH_W-1:0] r_hash, n_hash;
    logic              r_cut_done, n_cut_done;
    logic [HASH_W-1:0] s_rot_h, s_drop, s_new_hash;
    logic              s_push;
    t_res              s_push_data;

    assign s_rot_h = rotl(r_hash, 5'd1);
    assign s_drop  = rotl(w_tab_old, s_weff[4:0]);

    always_comb begin
        n_hash      = r_hash;
        n_cut_done  = r_cut_done;
        s_new_hash  = r_hash;
        s_push      = 1'b0;
        s_push_data = '{cut_offset: r_s2_pos, hash_matched: 1'b0};
        unique case (r_s2_op)
            OP_RESTART: begin
                n_hash     = '0;
                n_cut_done = 1'b0;
            end
            OP_DATA: begin
                // Bytes after a cut are dropped until the next restart.
                if (!r_cut_done) begin
                    priority if (r_s2_roll) begin
                        s_new_hash = s_rot_h ^ s_drop ^ r_s2_add;
                    end else if (r_s2_build) begin
                        s_new_hash = s_rot_h ^ r_s2_add;
                    end else begin
                        // still skipping: hold the hash
                        s_new_hash = r_hash;
                    end
                    n_hash = s_new_hash;
                    if (r_s2_comp) begin
                        priority if ((s_new_hash & r_mask) == '0) begin
                            s_push                   = 1'b1;
                            s_push_data.hash_matched = 1'b1;
                            n_cut_done               = 1'b1;
                        end else if (r_s2_at_max) begin
                            s_push     = 1'b1;
                            n_cut_done = 1'b1;
                        end else begin
                            s_push = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash     <= '0;
            r_cut_done <= 1'b0;
        end else begin
            r_hash     <= n_hash;
            r_cut_done <= n_cut_done;
        end
    end

    // ---------------------------------------------------------------
    // Result queue
    // ---------------------------------------------------------------
    t_res           r_fifo [FIFO_DEPTH];
    logic [FPW-1:0] r_head, r_tail;
    logic           s_pop;

    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_fifo[r_head];
    assign s_pop       = o_out_valid & ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_fifo[r_tail] <= s_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (s_push) begin
                r_tail <= r_tail + FPW'(1);
            end
            if (s_pop) begin
                r_head <= r_head + FPW'(1);
            end
            r_count <= r_count + FCW'(s_push) - FCW'(s_pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_push && !s_pop) |-> (r_count < FCW'(FIFO_DEPTH)))
        else $error("result queue overflow");

    a_cut_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_push |=> r_cut_done)
        else $error("cut emitted without latching cut_done");

    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cfg_we |=> o_in_stall)
        else $error("input taken before window modulo settled");

    a_wmod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_settle == 2'd0) |-> ((AW+1)'(r_wmod) < (AW+1)'(WINDOW_DEPTH)))
        else $error("window modulo out of ring range");
`endif

endmodule
